// ===== rtl/vca_pkg.sv =====
// ---------------------------------------------------------------------------
// vca_pkg
// Shared types, microcode program and preference tables of the voice
// channel allocator.
// ---------------------------------------------------------------------------
package vca_pkg;

  localparam int NumVoices = 16;
  localparam int VoiceW    = 4;
  localparam int PrioW     = 8;
  localparam int VolW      = 11;
  localparam int TypeW     = 2;
  localparam int LenW      = 5;
  localparam int StepW     = 3;

  localparam logic [VolW-1:0] VolFull = 11'h7FF;

  typedef logic [StepW-1:0] step_t;

  // Program addresses.
  localparam step_t StIdle   = 3'd0;
  localparam step_t StDisp   = 3'd1;
  localparam step_t StScan   = 3'd2;
  localparam step_t StDecide = 3'd3;
  localparam step_t StWrite  = 3'd4;
  localparam step_t StEmit   = 3'd5;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic [TypeW-1:0] TypeSample = 2'd0;
  localparam logic [TypeW-1:0] TypeTone   = 2'd1;
  localparam logic [TypeW-1:0] TypeNoise  = 2'd2;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LATCH,
    DP_SCAN,
    DP_DECIDE,
    DP_WRITE,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_NOSTART,
    CND_WRITE,
    CND_MORE
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ctrl_word_t;

  typedef struct packed {
    logic is_write;
    logic more;
  } dp_status_t;

  // Control store. Unused addresses return to idle.
  function automatic ctrl_word_t ucode_rom(input step_t addr);
    ctrl_word_t w;
    case (addr)
      StIdle:   w = '{op: DP_LATCH,  cond: CND_NOSTART, target: StIdle};
      StDisp:   w = '{op: DP_NOP,    cond: CND_WRITE,   target: StWrite};
      StScan:   w = '{op: DP_SCAN,   cond: CND_MORE,    target: StScan};
      StDecide: w = '{op: DP_DECIDE, cond: CND_ALWAYS,  target: StEmit};
      StWrite:  w = '{op: DP_WRITE,  cond: CND_NEXT,    target: StIdle};
      StEmit:   w = '{op: DP_EMIT,   cond: CND_ALWAYS,  target: StIdle};
      default:  w = '{op: DP_NOP,    cond: CND_ALWAYS,  target: StIdle};
    endcase
    return w;
  endfunction

  function automatic logic [LenW-1:0] pref_len(input logic [TypeW-1:0] vtype);
    logic [LenW-1:0] n;
    case (vtype)
      TypeSample: n = 5'd16;
      TypeTone:   n = 5'd6;
      TypeNoise:  n = 5'd2;
      default:    n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [VoiceW-1:0] pref_voice(input logic [TypeW-1:0] vtype,
                                                   input logic [VoiceW-1:0] pos);
    logic [VoiceW-1:0] v;
    v = '0;
    case (vtype)
      TypeSample: begin
        case (pos)
          4'd0:    v = 4'd4;
          4'd1:    v = 4'd5;
          4'd2:    v = 4'd6;
          4'd3:    v = 4'd7;
          4'd4:    v = 4'd2;
          4'd5:    v = 4'd0;
          4'd6:    v = 4'd3;
          4'd7:    v = 4'd1;
          4'd8:    v = 4'd8;
          4'd9:    v = 4'd9;
          4'd10:   v = 4'd10;
          4'd11:   v = 4'd11;
          4'd12:   v = 4'd14;
          4'd13:   v = 4'd12;
          4'd14:   v = 4'd15;
          default: v = 4'd13;
        endcase
      end
      TypeTone:  v = 4'd8 + pos;
      TypeNoise: v = 4'd14 + pos;
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/vca_seq.sv =====
// ---------------------------------------------------------------------------
// vca_seq
// Microcode sequencer: step counter, control store and jump logic.
// ---------------------------------------------------------------------------
module vca_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  vca_pkg::dp_status_t status,
  output vca_pkg::ctrl_word_t ctrl,
  output logic                busy
);
  import vca_pkg::*;

  step_t      pc_r, pc_nxt;
  ctrl_word_t word;
  logic       take;

  assign word = ucode_rom(pc_r);
  assign busy = (pc_r != StIdle);

  always_comb begin
    ctrl = word;
    // The idle step only latches an item when one is offered.
    if (pc_r == StIdle && !start) begin
      ctrl.op = DP_NOP;
    end
  end

  always_comb begin
    case (word.cond)
      CND_NEXT:    take = 1'b0;
      CND_ALWAYS:  take = 1'b1;
      CND_NOSTART: take = !start;
      CND_WRITE:   take = status.is_write;
      CND_MORE:    take = status.more;
      default:     take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= StIdle;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/vca_datapath.sv =====
// ---------------------------------------------------------------------------
// vca_datapath
// Voice tables, allowed mask, list walker and best-voice tracker.
// ---------------------------------------------------------------------------
module vca_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  vca_pkg::ctrl_word_t ctrl,
  output vca_pkg::dp_status_t status,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                in_operation,
  input  logic [1:0]          in_voice_type,
  input  logic [7:0]          in_request_priority,
  input  logic [3:0]          in_voice_index,
  input  logic [7:0]          in_voice_priority,
  input  logic [10:0]         in_voice_volume,
  output logic                out_strobe,
  output logic                out_granted,
  output logic [3:0]          out_granted_voice
);
  import vca_pkg::*;

  logic [PrioW-1:0]     prio_tab_r [NumVoices];
  logic [VolW-1:0]      vol_tab_r  [NumVoices];
  logic [NumVoices-1:0] mask_r;

  // Latched item.
  logic              op_r;
  logic [TypeW-1:0]  vtype_r;
  logic [PrioW-1:0]  req_prio_r;
  logic [VoiceW-1:0] widx_r;
  logic [PrioW-1:0]  wprio_r;
  logic [VolW-1:0]   wvol_r;

  logic [VoiceW-1:0] ptr_r, ptr_nxt;
  logic              found_r, found_nxt;
  logic [VoiceW-1:0] best_r, best_nxt;
  logic [PrioW-1:0]  best_prio_r, best_prio_nxt;
  logic [VolW-1:0]   best_vol_r, best_vol_nxt;
  logic              grant_r, grant_nxt;
  logic [VoiceW-1:0] gvoice_r, gvoice_nxt;
  logic              strobe_r, strobe_nxt;

  logic [LenW-1:0]   len;
  logic              in_list;
  logic [VoiceW-1:0] cand;
  logic [PrioW-1:0]  cand_prio;
  logic [VolW-1:0]   cand_vol;
  logic              better;
  logic              grant_ok;

  assign len       = pref_len(vtype_r);
  assign in_list   = ({1'b0, ptr_r} < len);
  assign cand      = pref_voice(vtype_r, ptr_r);
  assign cand_prio = prio_tab_r[cand];
  assign cand_vol  = vol_tab_r[cand];
  assign better    = (cand_prio < best_prio_r) ||
                     ((cand_prio == best_prio_r) && (cand_vol < best_vol_r));
  assign grant_ok  = found_r && (req_prio_r >= best_prio_r);

  assign status.is_write = op_r;
  assign status.more     = (({1'b0, ptr_r} + LenW'(1)) < len);

  always_comb begin
    ptr_nxt       = ptr_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_prio_nxt = best_prio_r;
    best_vol_nxt  = best_vol_r;
    grant_nxt     = grant_r;
    gvoice_nxt    = gvoice_r;
    strobe_nxt    = 1'b0;
    case (ctrl.op)
      DP_LATCH: begin
        ptr_nxt    = '0;
        found_nxt  = 1'b0;
        grant_nxt  = 1'b0;
        gvoice_nxt = '0;
      end
      DP_SCAN: begin
        ptr_nxt = ptr_r + VoiceW'(1);
        // The first allowed voice is taken as is; later ones must beat it.
        if (in_list && mask_r[cand] && (!found_r || better)) begin
          found_nxt     = 1'b1;
          best_nxt      = cand;
          best_prio_nxt = cand_prio;
          best_vol_nxt  = cand_vol;
        end
      end
      DP_DECIDE: begin
        if (grant_ok) begin
          grant_nxt  = 1'b1;
          gvoice_nxt = best_r;
        end
      end
      DP_EMIT: begin
        strobe_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumVoices; i++) begin
        prio_tab_r[i] <= '0;
        vol_tab_r[i]  <= '0;
      end
      mask_r   <= '0;
      strobe_r <= 1'b0;
      found_r  <= 1'b0;
      ptr_r    <= '0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_data;
      end
      if (ctrl.op == DP_WRITE) begin
        prio_tab_r[widx_r] <= wprio_r;
        vol_tab_r[widx_r]  <= wvol_r;
      end
      if (ctrl.op == DP_DECIDE && grant_ok) begin
        vol_tab_r[best_r] <= VolFull;
      end
      strobe_r <= strobe_nxt;
      found_r  <= found_nxt;
      ptr_r    <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == DP_LATCH) begin
      op_r       <= in_operation;
      vtype_r    <= in_voice_type;
      req_prio_r <= in_request_priority;
      widx_r     <= in_voice_index;
      wprio_r    <= in_voice_priority;
      wvol_r     <= in_voice_volume;
    end
    best_r      <= best_nxt;
    best_prio_r <= best_prio_nxt;
    best_vol_r  <= best_vol_nxt;
    grant_r     <= grant_nxt;
    gvoice_r    <= gvoice_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_granted       = grant_r;
  assign out_granted_voice = gvoice_r;

endmodule

// ===== rtl/voice_channel_allocator.sv =====
// ---------------------------------------------------------------------------
// voice_channel_allocator
// Picks the least important voice of a type's preference list for a new note
// and keeps per-voice priority and volume.
// ---------------------------------------------------------------------------
//  channel   ports                                   transfer when
//  input     start, busy, in_*                       start & !busy
//  result    out_strobe, out_granted*                out_strobe (one cycle)
//  config    cfg_valid, cfg_ready, cfg_data          cfg_valid & cfg_ready
//
// An allocate request passes the dispatch step, a scan of its type's preference
// list (16 voices for sample, 6 for tone, 2 for noise; an unused type's empty
// list still costs one scan step) and the decide and emit steps; a status
// write passes the dispatch, write and emit steps. The scan loop reads one
// voice of the list per cycle. busy drops in the cycle the result is shown,
// so the next item may transfer in that cycle. Reset restores all voice
// tables and the allowed mask to zero at once. Results cannot be held off.
// ---------------------------------------------------------------------------
module voice_channel_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [1:0]  in_voice_type,
  input  logic [7:0]  in_request_priority,
  input  logic [3:0]  in_voice_index,
  input  logic [7:0]  in_voice_priority,
  input  logic [10:0] in_voice_volume,
  output logic        out_strobe,
  output logic        out_granted,
  output logic [3:0]  out_granted_voice,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import vca_pkg::*;

  ctrl_word_t ctrl;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  vca_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  vca_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .status              (status),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_data            (cfg_data),
    .in_operation        (in_operation),
    .in_voice_type       (in_voice_type),
    .in_request_priority (in_request_priority),
    .in_voice_index      (in_voice_index),
    .in_voice_priority   (in_voice_priority),
    .in_voice_volume     (in_voice_volume),
    .out_strobe          (out_strobe),
    .out_granted         (out_granted),
    .out_granted_voice   (out_granted_voice)
  );

endmodule

// ===== rtl/vca_checker.sv =====
// ---------------------------------------------------------------------------
// vca_checker
// Port-level checks of the voice channel allocator, bound to the top level.
// ---------------------------------------------------------------------------
module vca_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_operation,
  input logic       out_strobe,
  input logic       out_granted,
  input logic [3:0] out_granted_voice
);

  // Every transfer in makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an input transfer");

  // A result is only shown once the sequencer is back at rest.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_zero_voice: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_granted) |-> (out_granted_voice == 4'd0))
    else $error("voice index not zero on a refused grant");

  // A status write passes the dispatch, write and emit steps and answers with no grant.
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation) |-> ##4 (out_strobe && !out_granted))
    else $error("status write result missing or granted");

endmodule

bind voice_channel_allocator vca_checker u_vca_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_operation      (in_operation),
  .out_strobe        (out_strobe),
  .out_granted       (out_granted),
  .out_granted_voice (out_granted_voice)
);
